>>> hdl/tota_pkg.sv
// Shared types and constants for the tracked object table with aging.
// Holds the status codes, controller states, the lookup beat struct passed along the cell chain and the command struct.
// No dependencies.
package tota_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // Reported counts stop at this value
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd20000;

  // Operation codes on the input channel
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_STALE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_TICK    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_COMMIT,
    S_DONE
  } state_t;

  // Lookup beat handed from one cell to the next
  typedef struct packed {
    logic active;
    logic hit;
    logic hit_newer;
    logic free_found;
  } probe_t;

  // Write command broadcast to all cells after the lookup pass
  typedef struct packed {
    logic write;
    logic insert;
  } cmd_t;

endpackage

>>> hdl/tota_cell.sv
// One table entry of the tracked object table: stores the entry and forwards the lookup beat.
// Depends on tota_pkg for the probe and command structs and field widths.
module tota_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Lookup beat from the previous cell
  input  tota_pkg::probe_t                  probe_i,
  input  logic [IDX_W-1:0]                  hit_idx_i,
  input  logic [IDX_W-1:0]                  free_idx_i,
  input  logic [CNT_W-1:0]                  removed_i,
  input  logic [CNT_W-1:0]                  occ_i,
  // Lookup beat to the next cell
  output tota_pkg::probe_t                  probe_o,
  output logic [IDX_W-1:0]                  hit_idx_o,
  output logic [IDX_W-1:0]                  free_idx_o,
  output logic [CNT_W-1:0]                  removed_o,
  output logic [CNT_W-1:0]                  occ_o,
  // Item broadcast from the controller
  input  logic                              op_i,
  input  logic [tota_pkg::ID_W-1:0]         id_i,
  input  logic [tota_pkg::TIME_W-1:0]       time_i,
  input  logic [tota_pkg::TIME_W-1:0]       max_age_i,
  input  logic signed [tota_pkg::POS_W-1:0] x_i,
  input  logic signed [tota_pkg::POS_W-1:0] y_i,
  input  logic signed [tota_pkg::POS_W-1:0] z_i,
  input  logic                              own_i,
  input  tota_pkg::cmd_t                    cmd_i,
  input  logic [IDX_W-1:0]                  cmd_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                              valid_r, valid_nxt;
  logic [tota_pkg::ID_W-1:0]         id_r;
  logic [tota_pkg::TIME_W-1:0]       time_r;
  logic signed [tota_pkg::POS_W-1:0] x_r, y_r, z_r;
  logic                              own_r;

  tota_pkg::probe_t                  probe_r, probe_nxt;
  logic [IDX_W-1:0]                  hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]                  free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]                  removed_r, removed_nxt;
  logic [CNT_W-1:0]                  occ_r, occ_nxt;

  logic                              id_match;
  logic                              expired;
  logic [tota_pkg::TIME_W-1:0]       age;
  logic                              cmd_here;

  // Compare this entry against the item on the broadcast bus
  assign id_match = valid_r && (id_r == id_i);
  assign age      = time_i - time_r;
  assign expired  = valid_r && (time_i > time_r) && (age > max_age_i);
  assign cmd_here = cmd_i.write && (cmd_idx_i == MY_IDX);

  // Fold this entry into the lookup beat
  always_comb begin
    probe_nxt        = probe_i;
    hit_idx_nxt      = hit_idx_i;
    free_idx_nxt     = free_idx_i;
    removed_nxt      = removed_i;
    occ_nxt          = occ_i;
    if (op_i == tota_pkg::OP_TICK) begin
      removed_nxt = removed_i + CNT_W'(expired);
      occ_nxt     = occ_i + CNT_W'(valid_r && !expired);
    end else begin
      occ_nxt = occ_i + CNT_W'(valid_r);
      if (!probe_i.hit && id_match) begin
        probe_nxt.hit       = 1'b1;
        probe_nxt.hit_newer = time_i > time_r;
        hit_idx_nxt         = MY_IDX;
      end
      if (!probe_i.free_found && !valid_r) begin
        probe_nxt.free_found = 1'b1;
        free_idx_nxt         = MY_IDX;
      end
    end
  end

  // Set on insert, drop on expiry during a tick pass
  always_comb begin
    valid_nxt = valid_r;
    if (cmd_here && cmd_i.insert) begin
      valid_nxt = 1'b1;
    end else if (probe_i.active && (op_i == tota_pkg::OP_TICK) && expired) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the entry valid bit and pass the lookup beat on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      probe_r <= probe_nxt;
    end
  end

  // Hand the beat payload on
  always_ff @(posedge clk) begin
    hit_idx_r          <= hit_idx_nxt;
    free_idx_r         <= free_idx_nxt;
    removed_r          <= removed_nxt;
    occ_r              <= occ_nxt;
  end

  // Write the entry contents on a command aimed at this cell
  always_ff @(posedge clk) begin
    if (cmd_here) begin
      x_r    <= x_i;
      y_r    <= y_i;
      z_r    <= z_i;
      time_r <= time_i;
      if (cmd_i.insert) begin
        id_r  <= id_i;
        own_r <= own_i;
      end else begin
        own_r <= own_r | own_i;
      end
    end
  end

  assign probe_o    = probe_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;
  assign removed_o  = removed_r;
  assign occ_o      = occ_r;

endmodule

>>> hdl/tracked_object_table_with_aging.sv
// Top level of the tracked object table with aging: controller and chain of entry cells.
// Depends on tota_pkg and tota_cell.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is a detection (in_op = 0) or a
//   tick (in_op = 1) carrying the current time. Result channel (out_valid /
//   out_stall): one beat per input beat with status, removed count and occupancy.
//   Configuration channel (cfg_valid / cfg_ready, always ready): writes max_age;
//   write it only while no item is in flight.
//   Timing: a lookup beat walks the cell chain one entry per cycle; after the
//   sweep the controller commits and then offers the result beat. in_stall is
//   high while an item is in work, so the next item can be accepted in the cycle
//   after that result is registered.
//   The result sits in an output register: a stalled receiver holds that beat,
//   the next item may still be accepted and worked, and its result waits in the
//   controller until the output register frees.
//   Reset (rst_n low, synchronous) empties the table, restores max_age to 20000
//   and drops any item or result in flight.
module tracked_object_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [tota_pkg::ID_W-1:0]         in_object_id,
  input  logic signed [tota_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [tota_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [tota_pkg::POS_W-1:0] in_pos_z,
  input  logic [tota_pkg::TIME_W-1:0]       in_event_time,
  input  logic                              in_own_detect,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tota_pkg::STATUS_W-1:0]     out_status,
  output logic [tota_pkg::COUNT_W-1:0]      out_removed_count,
  output logic [tota_pkg::COUNT_W-1:0]      out_occupied,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tota_pkg::TIME_W-1:0]       cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  tota_pkg::state_t                  state_r, state_nxt;
  logic [tota_pkg::TIME_W-1:0]       max_age_r;

  // Item registers
  logic                              op_r;
  logic [tota_pkg::ID_W-1:0]         id_r;
  logic signed [tota_pkg::POS_W-1:0] x_r, y_r, z_r;
  logic [tota_pkg::TIME_W-1:0]       time_r;
  logic                              own_r;
  logic                              launch_r;

  // Commit and result registers
  logic                              cmd_insert_r, cmd_insert_nxt;
  logic                              cmd_write_r, cmd_write_nxt;
  logic [IDX_W-1:0]                  cmd_idx_r, cmd_idx_nxt;
  tota_pkg::status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]                  removed_r, removed_nxt;
  logic [CNT_W-1:0]                  occ_r, occ_nxt;
  tota_pkg::cmd_t                    cmd;

  // Output register
  logic                              out_valid_r;
  logic [tota_pkg::STATUS_W-1:0]     out_status_r;
  logic [tota_pkg::COUNT_W-1:0]      out_removed_r, out_occ_r;

  logic                              in_accept;
  logic                              out_load;

  // Chain links
  tota_pkg::probe_t                  probe_c   [0:TABLE_DEPTH];
  logic [IDX_W-1:0]                  hit_idx_c [0:TABLE_DEPTH];
  logic [IDX_W-1:0]                  free_idx_c[0:TABLE_DEPTH];
  logic [CNT_W-1:0]                  removed_c [0:TABLE_DEPTH];
  logic [CNT_W-1:0]                  occ_c     [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]            active_vec;
  tota_pkg::probe_t                  last;

  assign in_stall  = (state_r != tota_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= tota_pkg::MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_age_r <= cfg_data;
    end
  end

  // Capture the item and launch the lookup beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_op;
      id_r   <= in_object_id;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      z_r    <= in_pos_z;
      time_r <= in_event_time;
      own_r  <= in_own_detect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= in_accept;
    end
  end

  // Head of the chain
  always_comb begin
    probe_c[0]            = '0;
    probe_c[0].active     = launch_r;
    hit_idx_c[0]          = '0;
    free_idx_c[0]         = '0;
    removed_c[0]          = '0;
    occ_c[0]              = '0;
  end

  assign cmd.write  = cmd_write_r && (state_r == tota_pkg::S_COMMIT);
  assign cmd.insert = cmd_insert_r;

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tota_cell #(
        .CELL_IDX (i),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .probe_i    (probe_c[i]),
        .hit_idx_i  (hit_idx_c[i]),
        .free_idx_i (free_idx_c[i]),
        .removed_i  (removed_c[i]),
        .occ_i      (occ_c[i]),
        .probe_o    (probe_c[i+1]),
        .hit_idx_o  (hit_idx_c[i+1]),
        .free_idx_o (free_idx_c[i+1]),
        .removed_o  (removed_c[i+1]),
        .occ_o      (occ_c[i+1]),
        .op_i       (op_r),
        .id_i       (id_r),
        .time_i     (time_r),
        .max_age_i  (max_age_r),
        .x_i        (x_r),
        .y_i        (y_r),
        .z_i        (z_r),
        .own_i      (own_r),
        .cmd_i      (cmd),
        .cmd_idx_i  (cmd_idx_r)
      );
      assign active_vec[i] = probe_c[i+1].active;
    end
  endgenerate

  assign last     = probe_c[TABLE_DEPTH];
  assign out_load = (state_r == tota_pkg::S_DONE) && (!out_valid_r || !out_stall);

  // Sequence one item: sweep the chain, commit, hand the result over
  always_comb begin
    state_nxt      = state_r;
    cmd_write_nxt  = cmd_write_r;
    cmd_insert_nxt = cmd_insert_r;
    cmd_idx_nxt    = cmd_idx_r;
    status_nxt     = status_r;
    removed_nxt    = removed_r;
    occ_nxt        = occ_r;
    case (state_r)
      tota_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = tota_pkg::S_SWEEP;
        end
      end
      tota_pkg::S_SWEEP: begin
        if (last.active) begin
          state_nxt      = tota_pkg::S_COMMIT;
          cmd_write_nxt  = 1'b0;
          cmd_insert_nxt = 1'b0;
          cmd_idx_nxt    = hit_idx_c[TABLE_DEPTH];
          removed_nxt    = '0;
          occ_nxt        = occ_c[TABLE_DEPTH];
          if (op_r == tota_pkg::OP_TICK) begin
            status_nxt  = tota_pkg::ST_TICK;
            removed_nxt = removed_c[TABLE_DEPTH];
          end else if (last.hit) begin
            cmd_write_nxt = last.hit_newer;
            status_nxt    = last.hit_newer ? tota_pkg::ST_UPDATED : tota_pkg::ST_STALE;
          end else if (last.free_found) begin
            cmd_write_nxt  = 1'b1;
            cmd_insert_nxt = 1'b1;
            cmd_idx_nxt    = free_idx_c[TABLE_DEPTH];
            status_nxt     = tota_pkg::ST_ADDED;
            occ_nxt        = occ_c[TABLE_DEPTH] + CNT_W'(1);
          end else begin
            status_nxt = tota_pkg::ST_FULL;
          end
        end
      end
      tota_pkg::S_COMMIT: begin
        state_nxt = tota_pkg::S_DONE;
      end
      tota_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = tota_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tota_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tota_pkg::S_IDLE;
      cmd_write_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_write_r <= cmd_write_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_insert_r <= cmd_insert_nxt;
    cmd_idx_r    <= cmd_idx_nxt;
    status_r     <= status_nxt;
    removed_r    <= removed_nxt;
    occ_r        <= occ_nxt;
  end

  // Output register: load on a free slot, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= status_r;
      out_removed_r <= (32'(removed_r) > 32'(tota_pkg::COUNT_MAX)) ?
                       tota_pkg::COUNT_MAX : tota_pkg::COUNT_W'(removed_r);
      out_occ_r     <= (32'(occ_r) > 32'(tota_pkg::COUNT_MAX)) ?
                       tota_pkg::COUNT_MAX : tota_pkg::COUNT_W'(occ_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_count = out_removed_r;
  assign out_occupied      = out_occ_r;

  // Only one lookup beat travels the chain at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(active_vec))
    else $error("more than one lookup beat in the cell chain");

  // The chain delivers its beat only while the controller sweeps
  a_last_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    last.active |-> (state_r == tota_pkg::S_SWEEP))
    else $error("lookup beat left the chain outside a sweep");

  // An accepted item always starts a beat at the head of the chain
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (launch_r && (state_r == tota_pkg::S_SWEEP)))
    else $error("accepted item did not launch a lookup beat");

  // Occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tota_pkg::S_DONE) |-> (32'(occ_r) <= 32'(TABLE_DEPTH)))
    else $error("occupancy above table depth");

endmodule
